// ===== rtl/ssot_pkg.sv =====
// ssot_pkg: shared constants, types and helpers for the scan seek scheduler
// used by scan_seek_order_total; depends on nothing else
`default_nettype none
package ssot_pkg;

   localparam int MAX_REQUESTS  = 32;
   localparam int POSITION_BITS = 16;

   // fixed field widths of the ports
   localparam int POS_W   = 16;
   localparam int DIST_W  = 16;
   localparam int TOTAL_W = 22;
   localparam int CSR_IDX_W = 2;

   localparam int ADDR_BITS  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_REQUESTS + 1);

   localparam logic [POS_W-1:0] POS_MASK =
      POS_W'((64'd1 << POSITION_BITS) - 64'd1);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_REQUESTS);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_END      = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_PLACE,
      S_BEGIN,
      S_SCAN,
      S_UP,
      S_SWEEP,
      S_DOWN
   } sched_state_type;

   function automatic logic [DIST_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
      logic [DIST_W-1:0] d;
      if (a > b) begin
         d = DIST_W'(a - b);
      end else begin
         d = DIST_W'(b - a);
      end
      return d;
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] s,
                                                  input logic [DIST_W-1:0] d);
      logic [TOTAL_W:0] t;
      logic [TOTAL_W-1:0] r;
      t = {1'b0, s} + (TOTAL_W+1)'(d);
      if (t > {1'b0, TOTAL_MAX}) begin
         r = TOTAL_MAX;
      end else begin
         r = t[TOTAL_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ssot_ram.sv =====
// ssot_ram: generic simple dual-port ram, one write and one registered read
// standalone; no package needed
`default_nettype none
module ssot_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/scan_seek_order_total.sv =====
// scan_seek_order_total: scan (elevator) seek scheduler for one batch of tracks
// uses ssot_pkg and one ssot_ram holding the requests in ascending order
//
// Usage: a request word is taken at a clock edge where start is high and busy
// is low. Each request is inserted into a sorted request ram as it arrives:
// after the accept edge, each stored entry above it is shifted up and then
// the new one is placed (the first word of a batch is written at once), all
// limited by the single ram write port. Requests past MAX_REQUESTS are
// dropped, their last flag still ends the batch. After the last request the
// block passes through a begin state, then scans up the ram for the first
// track above start_position (one entry per cycle), then emits one move per
// cycle: n + 1 moves in all, ascending requests, the move to sweep_end, then
// descending requests. Each move is held on the rsp_ ports for one cycle
// with rsp_valid high; the receiver cannot stall, the last move carries
// rsp_final_move. busy drops in the cycle the final move is shown. csr
// writes (start position, sweep end) take effect at once and are meant for
// idle time only. Reset clears the request count and running total and
// loads start_position 0 and sweep_end all ones; the ram needs no clearing.
`default_nettype none
module scan_seek_order_total (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ssot_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ssot_pkg::POS_W-1:0]          csr_wdata,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [ssot_pkg::POS_W-1:0]          req_request_position,
   input  wire logic                                req_request_last,
   output logic                                     rsp_valid,
   output logic      [ssot_pkg::POS_W-1:0]          rsp_from_position,
   output logic      [ssot_pkg::POS_W-1:0]          rsp_to_position,
   output logic      [ssot_pkg::DIST_W-1:0]         rsp_move_distance,
   output logic      [ssot_pkg::TOTAL_W-1:0]        rsp_running_total,
   output logic                                     rsp_final_move
);

   localparam int AW = ssot_pkg::ADDR_BITS;
   localparam int CW = ssot_pkg::COUNT_BITS;
   localparam int PW = ssot_pkg::POS_W;

   ssot_pkg::sched_state_type state_ff, state_in;

   logic [CW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   logic [CW-1:0]                  split_ff, split_in;
   logic [PW-1:0]                  head_ff, head_in;
   logic [ssot_pkg::TOTAL_W-1:0]   sum_ff, sum_in;
   logic [PW-1:0]                  newpos_ff, newpos_in;
   logic                           last_ff, last_in;
   logic [PW-1:0]                  start_pos_ff;
   logic [PW-1:0]                  sweep_end_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                  rsp_from_ff, rsp_from_in;
   logic [PW-1:0]                  rsp_to_ff, rsp_to_in;
   logic [ssot_pkg::DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic [ssot_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                           rsp_final_ff, rsp_final_in;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr;
   logic [PW-1:0]                  ram_wdata;
   logic [AW-1:0]                  ram_raddr;
   logic [PW-1:0]                  ram_rdata;

   // move datapath, shared by all emitting states
   logic                           emit;
   logic [PW-1:0]                  emit_from, emit_to;
   logic                           emit_final;
   logic [ssot_pkg::DIST_W-1:0]    emit_dist;
   logic [ssot_pkg::TOTAL_W-1:0]   emit_total;

   logic                           accept;
   logic [PW-1:0]                  req_pos;
   logic                           more_up;

   ssot_ram #(
      .WIDTH (PW),
      .DEPTH (ssot_pkg::MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy    = (state_ff != ssot_pkg::S_IDLE);
   assign accept  = start && !busy;
   assign req_pos = req_request_position & ssot_pkg::POS_MASK;
   assign more_up = ({1'b0, idx_ff} + (AW+1)'(1)) < (AW+1)'(count_ff);

   assign emit_dist  = ssot_pkg::abs_diff(emit_to, emit_from);
   assign emit_total = ssot_pkg::sat_add(sum_ff, emit_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
         sweep_end_ff <= 16'hFFFF & ssot_pkg::POS_MASK;
      end else if (csr_we) begin
         case (csr_index)
            ssot_pkg::CSR_START_POSITION: start_pos_ff <= csr_wdata & ssot_pkg::POS_MASK;
            ssot_pkg::CSR_SWEEP_END:      sweep_end_ff <= csr_wdata & ssot_pkg::POS_MASK;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssot_pkg::S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      split_ff     <= split_in;
      head_ff      <= head_in;
      newpos_ff    <= newpos_in;
      last_ff      <= last_in;
      rsp_from_ff  <= rsp_from_in;
      rsp_to_ff    <= rsp_to_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_total_ff <= rsp_total_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      split_in  = split_ff;
      head_in   = head_ff;
      sum_in    = sum_ff;
      newpos_in = newpos_ff;
      last_in   = last_ff;

      ram_we    = 1'b0;
      ram_waddr = idx_ff + AW'(1);
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff;

      emit       = 1'b0;
      emit_from  = head_ff;
      emit_to    = ram_rdata;
      emit_final = 1'b0;

      case (state_ff)
         ssot_pkg::S_IDLE: begin
            if (accept) begin
               newpos_in = req_pos;
               last_in   = req_request_last;
               if (count_ff < ssot_pkg::COUNT_MAX) begin
                  count_in = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     ram_wdata = req_pos;
                     if (req_request_last) begin
                        state_in = ssot_pkg::S_BEGIN;
                     end
                  end else begin
                     // walk down from the top entry, shifting larger ones up
                     idx_in    = AW'(count_ff - CW'(1));
                     ram_raddr = AW'(count_ff - CW'(1));
                     state_in  = ssot_pkg::S_INSERT;
                  end
               end else if (req_request_last) begin
                  state_in = ssot_pkg::S_BEGIN;
               end
            end
         end

         ssot_pkg::S_INSERT: begin
            ram_we = 1'b1;
            if (ram_rdata > newpos_ff) begin
               ram_wdata = ram_rdata;
               if (idx_ff == '0) begin
                  state_in = ssot_pkg::S_PLACE;
               end else begin
                  idx_in    = idx_ff - AW'(1);
                  ram_raddr = idx_ff - AW'(1);
               end
            end else begin
               ram_wdata = newpos_ff;
               state_in  = last_ff ? ssot_pkg::S_BEGIN : ssot_pkg::S_IDLE;
            end
         end

         ssot_pkg::S_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = newpos_ff;
            state_in  = last_ff ? ssot_pkg::S_BEGIN : ssot_pkg::S_IDLE;
         end

         // separate state so the first read never meets a write to entry zero
         ssot_pkg::S_BEGIN: begin
            idx_in    = '0;
            ram_raddr = '0;
            state_in  = ssot_pkg::S_SCAN;
         end

         ssot_pkg::S_SCAN: begin
            if (ram_rdata > start_pos_ff) begin
               emit      = 1'b1;
               emit_from = start_pos_ff;
               head_in   = ram_rdata;
               sum_in    = emit_total;
               split_in  = CW'(idx_ff);
               if (more_up) begin
                  idx_in    = idx_ff + AW'(1);
                  ram_raddr = idx_ff + AW'(1);
                  state_in  = ssot_pkg::S_UP;
               end else begin
                  state_in = ssot_pkg::S_SWEEP;
               end
            end else if (more_up) begin
               idx_in    = idx_ff + AW'(1);
               ram_raddr = idx_ff + AW'(1);
            end else begin
               split_in = count_ff;
               head_in  = start_pos_ff;
               state_in = ssot_pkg::S_SWEEP;
            end
         end

         ssot_pkg::S_UP: begin
            emit    = 1'b1;
            head_in = ram_rdata;
            sum_in  = emit_total;
            if (more_up) begin
               idx_in    = idx_ff + AW'(1);
               ram_raddr = idx_ff + AW'(1);
            end else begin
               state_in = ssot_pkg::S_SWEEP;
            end
         end

         ssot_pkg::S_SWEEP: begin
            emit       = 1'b1;
            emit_to    = sweep_end_ff;
            emit_final = (split_ff == '0);
            head_in    = sweep_end_ff;
            sum_in     = emit_total;
            if (split_ff == '0) begin
               count_in = '0;
               sum_in   = '0;
               state_in = ssot_pkg::S_IDLE;
            end else begin
               idx_in    = AW'(split_ff - CW'(1));
               ram_raddr = AW'(split_ff - CW'(1));
               state_in  = ssot_pkg::S_DOWN;
            end
         end

         ssot_pkg::S_DOWN: begin
            emit       = 1'b1;
            emit_final = (idx_ff == '0);
            head_in    = ram_rdata;
            sum_in     = emit_total;
            if (idx_ff == '0) begin
               count_in = '0;
               sum_in   = '0;
               state_in = ssot_pkg::S_IDLE;
            end else begin
               idx_in    = idx_ff - AW'(1);
               ram_raddr = idx_ff - AW'(1);
            end
         end

         default: begin
            state_in = ssot_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = emit;
      rsp_from_in  = emit_from;
      rsp_to_in    = emit_to;
      rsp_dist_in  = emit_dist;
      rsp_total_in = emit_total;
      rsp_final_in = emit_final;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_from_position = rsp_from_ff;
   assign rsp_to_position   = rsp_to_ff;
   assign rsp_move_distance = rsp_dist_ff;
   assign rsp_running_total = rsp_total_ff;
   assign rsp_final_move    = rsp_final_ff;

   // once moves start they come every cycle until the final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_move |=> rsp_valid)
      else $error("gap in move words of a batch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_move |=> !rsp_valid)
      else $error("move word after the final move");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_move |-> busy)
      else $error("block idle while the batch is still being emitted");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssot_pkg::COUNT_MAX)
      else $error("request count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(rsp_final_move)
      |-> rsp_running_total >= $past(rsp_running_total))
      else $error("running total went down within a batch");

   // a new batch may be accepted while the final move is shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_move |-> count_ff == '0 && sum_ff == '0)
      else $error("batch state not cleared after final move");

endmodule
`default_nettype wire
